### hw/rtl/lhp_pkg.sv
// Shared constants and widths for the latency histogram block.
`default_nettype none
package lhp_pkg;

  // Histogram geometry
  localparam int STAGE_COUNT  = 4;
  localparam int BUCKET_COUNT = 2048;
  localparam int MEM_DEPTH    = STAGE_COUNT * BUCKET_COUNT;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int BKT_W        = $clog2(BUCKET_COUNT);
  localparam int SCAN_W       = BKT_W + 1;

  // Counter and accumulator widths
  localparam int CNT_W   = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int TOTAL_W = CNT_W + BKT_W;
  localparam int WSUM_W  = CNT_W + 2 * BKT_W;
  localparam int SEEN_W  = TOTAL_W + 7;

  // Port field widths
  localparam int STAGE_IN_W   = 2;
  localparam int DUR_W        = 32;
  localparam int TOTAL_OUT_W  = 43;
  localparam int WSUM_OUT_W   = 54;
  localparam int BKT_OUT_W    = 11;

  // ns to us: floor(ns / 1000) == (ns * NS_RECIP) >> NS_SHIFT for any 32-bit ns
  localparam int MUL_B_W   = 29;
  localparam int PROD_W    = DUR_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] NS_RECIP = 29'd274877907;
  localparam int NS_SHIFT  = 38;
  localparam int US_W      = 23;

  // Percentile scaling: seen >= ceil(total*P/100) <=> seen*100 >= total*P
  localparam int PCT_SCALE = 100;
  localparam int PCT_50    = 50;
  localparam int PCT_95    = 95;
  localparam int PCT_99    = 99;

  // Item opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

endpackage
`default_nettype wire

### hw/rtl/lhp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lhp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/latency_histogram_percentiles.sv
// Per-stage latency histogram with total, weighted sum, max and percentile report.
//
// After reset the block runs a clearing pass over the 8192-entry counter RAM
// (one entry per cycle) with in_stall high; record_enable writes are taken
// throughout. A record transaction steps through ST_REC_MUL, ST_REC_RD and
// ST_REC_WR from acceptance to the next acceptance: one pass through the shared
// multiplier for the ns to us conversion, one RAM read, one saturating write
// back. A record while disabled or for an absent stage leaves the block in
// ST_IDLE. A report transaction scans the stage's BUCKET_COUNT counters twice
// through the single RAM read port and the shared multiplier (sums first, then
// percentiles) and waits in ST_DONE until the output register is free; an
// empty stage skips the second scan. The result sits in an output register,
// so records proceed while a report result waits.
`default_nettype none
module latency_histogram_percentiles
  import lhp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_wr_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   op,
  input  wire logic [STAGE_IN_W-1:0]  stage,
  input  wire logic [DUR_W-1:0]       duration_ns,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        not_empty,
  output logic [TOTAL_OUT_W-1:0]      total_count,
  output logic [WSUM_OUT_W-1:0]       weighted_sum_us,
  output logic [BKT_OUT_W-1:0]        max_bucket,
  output logic [BKT_OUT_W-1:0]        p50_bucket,
  output logic [BKT_OUT_W-1:0]        p95_bucket,
  output logic [BKT_OUT_W-1:0]        p99_bucket
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_MUL,
    ST_REC_RD,
    ST_REC_WR,
    ST_SCAN_SUM,
    ST_TARGET,
    ST_SCAN_PCT,
    ST_DONE
  } state_t;

  state_t state;

  logic              record_enable;
  logic [ADDR_W-1:0] clr_addr;
  logic [SCAN_W-1:0] scan_idx;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] rec_addr;
  logic [DUR_W-1:0]  ns_reg;

  // shared multiplier
  logic [DUR_W-1:0]   mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  // scan pipeline
  logic              d1_v;
  logic [BKT_W-1:0]  d1_idx;
  logic              d2_v;
  logic [CNT_W-1:0]  d2_n;
  logic [BKT_W-1:0]  d2_idx;

  // accumulators
  logic [TOTAL_W-1:0] total;
  logic [WSUM_W-1:0]  wsum;
  logic [BKT_W-1:0]   max_b;
  logic [SEEN_W-1:0]  seen100;
  logic [SEEN_W-1:0]  seen100_next;
  logic [SEEN_W-1:0]  tgt50;
  logic [SEEN_W-1:0]  tgt95;
  logic [SEEN_W-1:0]  tgt99;
  logic               f50, f95, f99;
  logic [BKT_W-1:0]   p50, p95, p99;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  logic              in_acc;
  logic              stage_ok;
  logic              scanning;
  logic              issuing;
  logic              pipe_empty;
  logic [US_W-1:0]   rec_us;
  logic [BKT_W-1:0]  rec_bucket;
  logic [ADDR_W-1:0] rec_addr_next;
  logic              out_free;

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign stage_ok   = ({30'd0, stage} < 32'(STAGE_COUNT));
  assign scanning   = (state == ST_SCAN_SUM) || (state == ST_SCAN_PCT);
  assign issuing    = scan_idx < SCAN_W'(BUCKET_COUNT);
  assign pipe_empty = !issuing && !d1_v && !d2_v;
  assign out_free   = !out_valid || !out_stall;

  // ns to us conversion result and clamp to the last bucket
  assign rec_us        = prod[NS_SHIFT +: US_W];
  assign rec_bucket    = (rec_us >= US_W'(BUCKET_COUNT)) ? BKT_W'(BUCKET_COUNT - 1)
                                                         : rec_us[BKT_W-1:0];
  assign rec_addr_next = base_addr + ADDR_W'(rec_bucket);

  // shared multiplier operand select
  always_comb begin
    mul_a = ram_rdata;
    mul_b = MUL_B_W'(PCT_SCALE);
    if (state == ST_REC_MUL) begin
      mul_a = ns_reg;
      mul_b = NS_RECIP;
    end else if (state == ST_SCAN_SUM) begin
      mul_b = MUL_B_W'(d1_idx);
    end
  end

  // RAM access select: clearing pass, record read and write back, scan reads
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rec_addr;
    ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_REC_WR) begin
      ram_we    = 1'b1;
    end
    ram_re    = (state == ST_REC_RD) || (scanning && issuing);
    ram_raddr = (state == ST_REC_RD) ? rec_addr_next
                                     : base_addr + ADDR_W'(scan_idx[BKT_W-1:0]);
  end

  lhp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      record_enable <= 1'b0;
      clr_addr      <= '0;
      scan_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        record_enable <= cfg_wr_data;
      end
      // a result taken while the next one is loaded is handled in ST_DONE
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (scanning && issuing) begin
        scan_idx <= scan_idx + SCAN_W'(1);
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            ns_reg    <= duration_ns;
            base_addr <= ADDR_W'(stage) * ADDR_W'(BUCKET_COUNT);
            scan_idx  <= '0;
            if (op == OP_REPORT) begin
              state <= stage_ok ? ST_SCAN_SUM : ST_DONE;
            end else if (record_enable && stage_ok) begin
              state <= ST_REC_MUL;
            end
          end
        end
        ST_REC_MUL: state <= ST_REC_RD;
        ST_REC_RD: begin
          rec_addr <= rec_addr_next;
          state    <= ST_REC_WR;
        end
        ST_REC_WR: state <= ST_IDLE;
        ST_SCAN_SUM: begin
          if (pipe_empty) begin
            state <= (total == '0) ? ST_DONE : ST_TARGET;
          end
        end
        ST_TARGET: begin
          scan_idx <= '0;
          state    <= ST_SCAN_PCT;
        end
        ST_SCAN_PCT: begin
          if (pipe_empty) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            not_empty       <= (total != '0);
            total_count     <= TOTAL_OUT_W'(total);
            weighted_sum_us <= WSUM_OUT_W'(wsum);
            max_bucket      <= BKT_OUT_W'(max_b);
            p50_bucket      <= BKT_OUT_W'(p50);
            p95_bucket      <= BKT_OUT_W'(p95);
            p99_bucket      <= BKT_OUT_W'(p99);
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= 1'b0;
      d2_v <= 1'b0;
    end else begin
      d1_v <= scanning && issuing;
      d2_v <= d1_v;
    end
  end

  // Datapath: multiplier register, pipeline payload, accumulators
  assign seen100_next = seen100 + SEEN_W'(prod);

  always_ff @(posedge clk) begin
    prod   <= PROD_W'(mul_a) * PROD_W'(mul_b);
    d1_idx <= scan_idx[BKT_W-1:0];
    d2_n   <= ram_rdata;
    d2_idx <= d1_idx;

    // new report: clear all accumulators
    if (in_acc && op == OP_REPORT) begin
      total   <= '0;
      wsum    <= '0;
      max_b   <= '0;
      seen100 <= '0;
      f50     <= 1'b0;
      f95     <= 1'b0;
      f99     <= 1'b0;
      p50     <= '0;
      p95     <= '0;
      p99     <= '0;
    end

    // first scan: count, weighted sum, highest nonzero bucket
    if (state == ST_SCAN_SUM && d2_v) begin
      total <= total + TOTAL_W'(d2_n);
      wsum  <= wsum + WSUM_W'(prod);
      if (d2_n != '0) begin
        max_b <= d2_idx;
      end
    end

    // percentile targets scaled by 100
    if (state == ST_TARGET) begin
      tgt50 <= SEEN_W'(total) * SEEN_W'(PCT_50);
      tgt95 <= SEEN_W'(total) * SEEN_W'(PCT_95);
      tgt99 <= SEEN_W'(total) * SEEN_W'(PCT_99);
    end

    // second scan: cumulative count against each target
    if (state == ST_SCAN_PCT && d2_v && d2_n != '0 && !f99) begin
      seen100 <= seen100_next;
      if (!f50 && seen100_next >= tgt50) begin
        p50 <= d2_idx;
        f50 <= 1'b1;
      end
      if (!f95 && seen100_next >= tgt95) begin
        p95 <= d2_idx;
        f95 <= 1'b1;
      end
      if (seen100_next >= tgt99) begin
        p99 <= d2_idx;
        f99 <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lhp_checker.sv
// Port-level assertions for the latency histogram block, with its bind.
`default_nettype none
module lhp_checker
  import lhp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   not_empty,
  input wire logic [TOTAL_OUT_W-1:0] total_count,
  input wire logic [WSUM_OUT_W-1:0]  weighted_sum_us,
  input wire logic [BKT_OUT_W-1:0]   max_bucket,
  input wire logic [BKT_OUT_W-1:0]   p50_bucket,
  input wire logic [BKT_OUT_W-1:0]   p95_bucket,
  input wire logic [BKT_OUT_W-1:0]   p99_bucket
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // the clearing pass holds off input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("input taken during clearing pass");

  // an empty stage reports all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !not_empty |-> total_count == '0 && weighted_sum_us == '0 &&
      max_bucket == '0 && p50_bucket == '0 && p95_bucket == '0 && p99_bucket == '0)
    else $error("empty report has nonzero fields");

  // percentiles are ordered and lie at or below the highest bucket
  a_pct_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_empty |-> total_count != '0 && p50_bucket <= p95_bucket &&
      p95_bucket <= p99_bucket && p99_bucket <= max_bucket)
    else $error("percentile buckets out of order");

endmodule

bind latency_histogram_percentiles lhp_checker u_lhp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .not_empty       (not_empty),
  .total_count     (total_count),
  .weighted_sum_us (weighted_sum_us),
  .max_bucket      (max_bucket),
  .p50_bucket      (p50_bucket),
  .p95_bucket      (p95_bucket),
  .p99_bucket      (p99_bucket)
);
`default_nettype wire

### tb/sv/latency_histogram_percentiles_test.sv
// Testbench for the per-stage latency histogram: directed table, random traffic, scoreboard.
module latency_histogram_percentiles_test;
  import lhp_pkg::*;

  // Expected report contents
  typedef struct packed {
    logic                   not_empty;
    logic [TOTAL_OUT_W-1:0] total;
    logic [WSUM_OUT_W-1:0]  wsum;
    logic [BKT_OUT_W-1:0]   max_b;
    logic [BKT_OUT_W-1:0]   p50;
    logic [BKT_OUT_W-1:0]   p95;
    logic [BKT_OUT_W-1:0]   p99;
  } stage_stats_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              cfg_val;
    logic              row_op;
    logic [1:0]        row_stage;
    logic [DUR_W-1:0]  row_ns;
    bit                typed;
    stage_stats_t      want;
  } dir_row_t;

  localparam stage_stats_t STATS_EMPTY = '0;
  // single sample sitting in bucket zero: every percentile lands there
  localparam stage_stats_t STATS_ONE_AT_ZERO = '{not_empty: 1'b1, total: 43'd1, default: '0};
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 10000;
  localparam int NUM_DIR_ROWS  = 21;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   op = OP_RECORD;
  logic [STAGE_IN_W-1:0]  stage = '0;
  logic [DUR_W-1:0]       duration_ns = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   not_empty;
  logic [TOTAL_OUT_W-1:0] total_count;
  logic [WSUM_OUT_W-1:0]  weighted_sum_us;
  logic [BKT_OUT_W-1:0]   max_bucket;
  logic [BKT_OUT_W-1:0]   p50_bucket;
  logic [BKT_OUT_W-1:0]   p95_bucket;
  logic [BKT_OUT_W-1:0]   p99_bucket;

  // Shadow histogram and pending reports
  bit [CNT_W-1:0] bucket_hits [STAGE_COUNT][BUCKET_COUNT];
  bit             rec_enable = 1'b0;
  stage_stats_t   results_due [$];
  int             mismatch_count = 0;
  int             reports_sent = 0;

  // Traffic shaping
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd0, 32'd0,          1'b1, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd1, 32'd5000,       1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd1, 32'd0,          1'b1, STATS_EMPTY},
    '{ROW_CFG,  1'b1, OP_RECORD, 2'd0, 32'd0,          1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'd0,          1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd0, 32'hFFFFFFFF,   1'b1, STATS_ONE_AT_ZERO},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'd999,        1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'd1000,       1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'd2047999,    1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'd2048000,    1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd0, 32'hFFFFFFFF,   1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd0, 32'd0,          1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd2, 32'hAAAAAAAA,   1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd3, 32'h55555555,   1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd3, 32'd1234567,    1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd2, 32'h55555555,   1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd3, 32'hAAAAAAAA,   1'b0, STATS_EMPTY},
    '{ROW_CFG,  1'b0, OP_RECORD, 2'd0, 32'd0,          1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_RECORD, 2'd3, 32'd7000,       1'b0, STATS_EMPTY},
    '{ROW_ITEM, 1'b0, OP_REPORT, 2'd3, 32'd0,          1'b0, STATS_EMPTY},
    '{ROW_CFG,  1'b1, OP_RECORD, 2'd0, 32'd0,          1'b0, STATS_EMPTY}
  };

  latency_histogram_percentiles dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .stage           (stage),
    .duration_ns     (duration_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .not_empty       (not_empty),
    .total_count     (total_count),
    .weighted_sum_us (weighted_sum_us),
    .max_bucket      (max_bucket),
    .p50_bucket      (p50_bucket),
    .p95_bucket      (p95_bucket),
    .p99_bucket      (p99_bucket)
  );

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Saturating bucket update for one record transaction
  task automatic record_duration(input logic [1:0] stg, input logic [DUR_W-1:0] ns);
    int unsigned us;
    if (!rec_enable) return;
    us = ns / 1000;
    if (us >= BUCKET_COUNT) us = BUCKET_COUNT - 1;
    if (bucket_hits[stg][us] != CNT_MAX) bucket_hits[stg][us] += 1;
  endtask

  // Totals, max and percentile buckets of one stage
  function automatic stage_stats_t stage_summary(input logic [1:0] stg);
    stage_stats_t s;
    longint unsigned total, wsum, seen, t50, t95, t99, n;
    int max_b, p50, p95, p99;
    bit f50, f95, f99;
    s = '0;
    total = 0; wsum = 0; seen = 0; max_b = 0;
    p50 = 0; p95 = 0; p99 = 0;
    f50 = 0; f95 = 0; f99 = 0;
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      n = bucket_hits[stg][i];
      total += n;
      wsum += n * i;
      if (n != 0) max_b = i;
    end
    if (total == 0) return s;
    t50 = (total * 50 + 99) / 100;
    t95 = (total * 95 + 99) / 100;
    t99 = (total * 99 + 99) / 100;
    // found flags keep a percentile in bucket zero distinct from "not yet located"
    for (int i = 0; i < BUCKET_COUNT && !f99; i++) begin
      n = bucket_hits[stg][i];
      seen += n;
      if (n != 0 && !f50 && seen >= t50) begin p50 = i; f50 = 1; end
      if (n != 0 && !f95 && seen >= t95) begin p95 = i; f95 = 1; end
      if (n != 0 && !f99 && seen >= t99) begin p99 = i; f99 = 1; end
    end
    s.not_empty = 1'b1;
    s.total = total[TOTAL_OUT_W-1:0];
    s.wsum  = wsum[WSUM_OUT_W-1:0];
    s.max_b = max_b[BKT_OUT_W-1:0];
    s.p50   = p50[BKT_OUT_W-1:0];
    s.p95   = p95[BKT_OUT_W-1:0];
    s.p99   = p99[BKT_OUT_W-1:0];
    return s;
  endfunction

  // Offer one transaction after a random gap; update the shadow state on acceptance
  task automatic send_item(input logic item_op, input logic [1:0] item_stage,
                           input logic [DUR_W-1:0] item_ns, input bit typed,
                           input stage_stats_t want);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= item_op;
    stage       <= item_stage;
    duration_ns <= item_ns;
    do @(posedge clk); while (in_stall);
    if (item_op == OP_RECORD) begin
      record_duration(item_stage, item_ns);
    end else begin
      results_due.push_back(typed ? want : stage_summary(item_stage));
      reports_sent++;
    end
  endtask

  // Let all pending reports drain and the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic val);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rec_enable = val;
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Scoreboard: compare each result transaction with the oldest pending report
  always @(posedge clk) begin
    stage_stats_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected result, total_count", total_count, 0);
      end else begin
        want = results_due.pop_front();
        if (not_empty !== want.not_empty) flag_mismatch("not_empty", not_empty, want.not_empty);
        if (total_count !== want.total) flag_mismatch("total_count", total_count, want.total);
        if (weighted_sum_us !== want.wsum)
          flag_mismatch("weighted_sum_us", weighted_sum_us, want.wsum);
        if (max_bucket !== want.max_b) flag_mismatch("max_bucket", max_bucket, want.max_b);
        if (p50_bucket !== want.p50) flag_mismatch("p50_bucket", p50_bucket, want.p50);
        if (p95_bucket !== want.p95) flag_mismatch("p95_bucket", p95_bucket, want.p95);
        if (p99_bucket !== want.p99) flag_mismatch("p99_bucket", p99_bucket, want.p99);
      end
    end
  end

  // Stimulus
  initial begin
    int               phase_items [4] = '{300, 250, 60, 250};
    bit               phase_en    [4] = '{1'b1, 1'b1, 1'b0, 1'b1};
    int               phase_tx    [4] = '{26, 53, 0, 0};
    int               phase_rx    [4] = '{53, 26, 0, 0};
    int               n;
    logic             item_op;
    logic [1:0]       item_stage;
    logic [DUR_W-1:0] item_ns;

    @(posedge clk);
    while (rst) @(posedge clk);
    tx_idle_pct <= phase_tx[0];
    rx_idle_pct <= phase_rx[0];

    // Directed table
    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_enable(dir_rows[r].cfg_val);
      else
        send_item(dir_rows[r].row_op, dir_rows[r].row_stage, dir_rows[r].row_ns,
                  dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases
    for (int p = 0; p < 4; p++) begin
      write_enable(phase_en[p]);
      tx_idle_pct <= phase_tx[p];
      rx_idle_pct <= phase_rx[p];
      if (p == 3) begin
        // long receiver hold-off while reports keep coming: output and input both back up
        hold_go <= 1'b1;
        for (int k = 0; k < 3; k++)
          send_item(OP_REPORT, k[1:0], $urandom(), 1'b0, STATS_EMPTY);
        for (int k = 0; k < 6; k++)
          send_item(OP_RECORD, 2'($urandom_range(3)), $urandom_range(0, 50000), 1'b0,
                    STATS_EMPTY);
      end
      n = 0;
      while (n < phase_items[p] || (p == 3 && reports_sent < 40)) begin
        item_op    = ($urandom_range(99) < 6) ? OP_REPORT : OP_RECORD;
        item_stage = 2'($urandom_range(3));
        case ($urandom_range(9))
          0, 1, 2, 3: item_ns = $urandom_range(0, 20000);
          4, 5:       item_ns = $urandom_range(0, 2047999);
          6:          item_ns = $urandom_range(2047000, 2049999);
          7, 8:       item_ns = $urandom();
          default:    item_ns = item_stage * 3000 + $urandom_range(0, 1999);
        endcase
        send_item(item_op, item_stage, item_ns, 1'b0, STATS_EMPTY);
        n++;
      end
    end

    // Drain and finish
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
